// ----- hdl/bfm_pkg.sv -----
// ----------------------------------------------------------------------------
// bfm_pkg: shared types and constants of the 5x5 mean filter
// Field widths, register indexes and the constants of the mean division.
// ----------------------------------------------------------------------------
package bfm_pkg;

    // Field widths of the words on the channels.
    localparam int CHAN_W   = 8;
    localparam int PIX_W    = 3 * CHAN_W;
    localparam int COORD_W  = 10;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 2;

    // Window geometry.
    localparam int WINDOW   = 5;
    localparam int LINES    = WINDOW - 1;
    localparam int MAX_RES  = 9;

    // Sums: a column of five bytes fits 11 bits, the whole window 13 bits.
    localparam int COLSUM_W = 11;
    localparam int SUM_W    = 13;

    // floor(x / 25) == (x * 5243) >> 17 for every x below 6400.
    localparam int ROUND       = 12;
    localparam int RECIP       = 5243;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 17;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Reset values of the dimension registers.
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    // Register indexes on the configuration channel.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } t_cfg_idx;

    typedef logic [CHAN_W-1:0] t_chan;

endpackage

// ----- hdl/bfm_if.sv -----
// ----------------------------------------------------------------------------
// bfm_if: channel interfaces of the 5x5 mean filter
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------

// Pixel channel: one RGB pixel per word.
interface bfm_pix_if
    import bfm_pkg::*;
();
    logic  valid;
    logic  ready;
    t_chan channel_first;
    t_chan channel_second;
    t_chan channel_third;

    modport source(output valid, channel_first, channel_second, channel_third,
                   input ready);
    modport sink(input valid, channel_first, channel_second, channel_third,
                 output ready);
endinterface

// Result channel: one output pixel with its coordinates per word.
interface bfm_res_if
    import bfm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] out_column;
    logic [COORD_W-1:0] out_row;
    t_chan              mean_first;
    t_chan              mean_second;
    t_chan              mean_third;
    logic               group_end;

    modport source(output valid, out_column, out_row, mean_first, mean_second,
                   mean_third, group_end, input ready);
    modport sink(input valid, out_column, out_row, mean_first, mean_second,
                 mean_third, group_end, output ready);
endinterface

// Configuration channel: one register write per word.
interface bfm_cfg_if
    import bfm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/bfm_ram.sv -----
// ----------------------------------------------------------------------------
// bfm_ram: generic single-clock RAM
// One write port, one read port with registered, read-first output.
// ----------------------------------------------------------------------------
module bfm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/box_filter_5x5_rgb_edge_replicate.sv -----
// ----------------------------------------------------------------------------
// box_filter_5x5_rgb_edge_replicate: 5x5 mean filter with replicated border
// Four line RAMs feed a 5x5 window; each channel is replaced by the rounded
// window mean, which is sent once for every output position clamping to it.
// ----------------------------------------------------------------------------
//
//  Port     Direction  Word
//  i_pix    sink       one RGB input pixel, raster order
//  o_res    source     one output pixel: column, row, three means, group end
//  i_cfg    sink       one register write: index and data (always ready)
//
//  A pixel is taken every clock while the result side keeps up and no burst is
//  under way. A window centre passes the five-stage pipeline, then the emitter.
//  A centre on the border yields up to nine words from the single emitter, which
//  holds the pipeline and the input until its burst ends. Reset clears the
//  counters and sets the dimensions to 640x480; the line RAMs are not cleared,
//  as every row is written before it is read. A register write restarts the frame.
//
module box_filter_5x5_rgb_edge_replicate
    import bfm_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bfm_pix_if.sink       i_pix,
    bfm_res_if.source     o_res,
    bfm_cfg_if.sink       i_cfg
);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WDW = $clog2(MAX_WIDTH + 1);
    localparam int HDW = $clog2(MAX_HEIGHT + 1);

    typedef struct packed {
        logic          has_res;
        logic [CW-1:0] x0;
        logic [CW-1:0] x1;
        logic [RW-1:0] y0;
        logic [RW-1:0] y1;
    } t_span;

    // Configuration registers and the effective dimensions.
    logic [CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [WDW-1:0]   w_eff;
    logic [HDW-1:0]   h_eff;
    logic             cfg_wr, cfg_restart;

    // Position counters.
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    // Pipeline control.
    logic adv, accept;

    // Stage 1: line RAM read data and the pixel.
    logic             r_s1_v;
    logic [CW-1:0]    r_s1_col;
    logic [RW-1:0]    r_s1_row;
    logic [PIX_W-1:0] r_s1_pix;
    logic [PIX_W-1:0] rdata [LINES];
    logic [PIX_W-1:0] win_col [WINDOW];

    // Window and later stages.
    logic [PIX_W-1:0]    r_win [WINDOW][WINDOW];
    logic                r_s2_v;
    logic [CW-1:0]       r_s2_col;
    logic [RW-1:0]       r_s2_row;
    t_span               s2_span;
    logic [COLSUM_W-1:0] colsum [3][WINDOW];
    logic                r_s3_v;
    t_span               r_s3_span;
    logic [COLSUM_W-1:0] r_s3_cs [3][WINDOW];
    logic                r_s4_v;
    t_span               r_s4_span;
    logic [SUM_W-1:0]    r_s4_tot [3];
    logic                r_s5_v;
    t_span               r_s5_span;
    logic [PROD_W-1:0]   r_s5_prod [3];

    // Emitter and output register.
    logic          r_e_v;
    t_span         r_e_span;
    t_chan         r_e_mean [3];
    logic [CW-1:0] r_e_ox;
    logic [RW-1:0] r_e_oy;
    logic [3:0]    r_e_n;
    logic          e_last, o_free, emit;

    logic               r_o_v;
    logic [COORD_W-1:0] r_o_col, r_o_row;
    t_chan              r_o_mean [3];
    logic               r_o_end;

    // Dimension saturation to [5, MAX].
    always_comb begin
        if (r_cfg_w < CFG_W'(WINDOW)) begin
            w_eff = WDW'(WINDOW);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_eff = WDW'(MAX_WIDTH);
        end else begin
            w_eff = WDW'(r_cfg_w);
        end
        if (r_cfg_h < CFG_W'(WINDOW)) begin
            h_eff = HDW'(WINDOW);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            h_eff = HDW'(MAX_HEIGHT);
        end else begin
            h_eff = HDW'(r_cfg_h);
        end
    end

    // Configuration writes; a known index restarts the frame.
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;
    assign cfg_restart = cfg_wr && (i_cfg.index == CFG_IMAGE_WIDTH ||
                                    i_cfg.index == CFG_IMAGE_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= WIDTH_RESET;
            r_cfg_h <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (i_cfg.index)
                CFG_IMAGE_WIDTH:  r_cfg_w <= i_cfg.data;
                CFG_IMAGE_HEIGHT: r_cfg_h <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Handshake: the whole pipeline moves unless the emitter holds a word that is not its last or cannot go out.
    assign o_free      = !r_o_v || o_res.ready;
    assign e_last      = (r_e_ox == r_e_span.x1 && r_e_oy == r_e_span.y1) ||
                         r_e_n == 4'(MAX_RES - 1);
    assign emit        = r_e_v && o_free;
    assign adv         = !r_e_v || (o_free && e_last);
    assign i_pix.ready = adv;
    assign accept      = i_pix.valid && adv;

    // Position counters in raster order.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (WDW'(r_col) + WDW'(1) == w_eff) begin
            n_col = '0;
            n_row = (HDW'(r_row) + HDW'(1) == h_eff) ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line RAMs: slot s holds rows with row mod 4 == s.
    for (genvar s = 0; s < LINES; s++) begin : g_line
        bfm_ram #(
            .WIDTH(PIX_W),
            .DEPTH(MAX_WIDTH)
        ) u_line (
            .i_clk  (i_clk),
            .i_we   (accept && r_row[1:0] == 2'(s)),
            .i_waddr(r_col),
            .i_wdata({i_pix.channel_third, i_pix.channel_second,
                      i_pix.channel_first}),
            .i_re   (accept),
            .i_raddr(r_col),
            .o_rdata(rdata[s])
        );
    end

    // Stage 1 side information.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (adv) begin
            r_s1_v <= accept;
        end
        if (accept) begin
            r_s1_col <= r_col;
            r_s1_row <= r_row;
            r_s1_pix <= {i_pix.channel_third, i_pix.channel_second,
                         i_pix.channel_first};
        end
    end

    // New window column, oldest row first.
    always_comb begin
        for (int k = 0; k < LINES; k++) begin
            win_col[k] = rdata[2'(r_s1_row[1:0] + 2'(k))];
        end
        win_col[WINDOW-1] = r_s1_pix;
    end

    // Window shift, one column per pixel.
    always_ff @(posedge i_clk) begin
        if (adv && r_s1_v) begin
            for (int k = 0; k < WINDOW; k++) begin
                for (int j = 0; j < WINDOW - 1; j++) begin
                    r_win[k][j] <= r_win[k][j+1];
                end
                r_win[k][WINDOW-1] <= win_col[k];
            end
        end
    end

    // Output span of the centre two rows and columns back.
    always_comb begin
        logic [CW-1:0] cx;
        logic [RW-1:0] cy;
        cx = r_s2_col - CW'(2);
        cy = r_s2_row - RW'(2);
        s2_span.has_res = r_s2_col >= CW'(4) && r_s2_row >= RW'(4);
        s2_span.x0 = (cx == CW'(2)) ? '0 : cx;
        s2_span.x1 = (WDW'(cx) == w_eff - WDW'(3)) ? CW'(w_eff - WDW'(1)) : cx;
        s2_span.y0 = (cy == RW'(2)) ? '0 : cy;
        s2_span.y1 = (HDW'(cy) == h_eff - HDW'(3)) ? RW'(h_eff - HDW'(1)) : cy;
    end

    // Column sums of the window, per channel.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int j = 0; j < WINDOW; j++) begin
                colsum[ch][j] = '0;
                for (int k = 0; k < WINDOW; k++) begin
                    colsum[ch][j] = colsum[ch][j] +
                                    COLSUM_W'(r_win[k][j][ch*CHAN_W +: CHAN_W]);
                end
            end
        end
    end

    // Stages 2 to 5: sums, rounding, reciprocal multiply.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else if (adv) begin
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
        end
        if (adv) begin
            r_s2_col  <= r_s1_col;
            r_s2_row  <= r_s1_row;
            r_s3_span <= s2_span;
            r_s3_cs   <= colsum;
            r_s4_span <= r_s3_span;
            r_s5_span <= r_s4_span;
            for (int ch = 0; ch < 3; ch++) begin
                r_s4_tot[ch] <= SUM_W'(r_s3_cs[ch][0]) + SUM_W'(r_s3_cs[ch][1]) +
                                SUM_W'(r_s3_cs[ch][2]) + SUM_W'(r_s3_cs[ch][3]) +
                                SUM_W'(r_s3_cs[ch][4]) + SUM_W'(ROUND);
                r_s5_prod[ch] <= PROD_W'(r_s4_tot[ch]) * PROD_W'(RECIP);
            end
        end
    end

    // Emitter: walks the span row by row, at most nine positions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (adv) begin
            r_e_v <= r_s5_v && r_s5_span.has_res;
        end
        if (adv) begin
            r_e_span <= r_s5_span;
            r_e_ox   <= r_s5_span.x0;
            r_e_oy   <= r_s5_span.y0;
            r_e_n    <= '0;
            for (int ch = 0; ch < 3; ch++) begin
                r_e_mean[ch] <= r_s5_prod[ch][RECIP_SHIFT +: CHAN_W];
            end
        end else if (emit) begin
            r_e_n <= r_e_n + 4'd1;
            if (r_e_ox == r_e_span.x1) begin
                r_e_ox <= r_e_span.x0;
                r_e_oy <= r_e_oy + RW'(1);
            end else begin
                r_e_ox <= r_e_ox + CW'(1);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (o_free) begin
            r_o_v <= emit;
        end
        if (emit) begin
            r_o_col  <= COORD_W'(r_e_ox);
            r_o_row  <= COORD_W'(r_e_oy);
            r_o_mean <= r_e_mean;
            r_o_end  <= e_last;
        end
    end

    assign o_res.valid       = r_o_v;
    assign o_res.out_column  = r_o_col;
    assign o_res.out_row     = r_o_row;
    assign o_res.mean_first  = r_o_mean[0];
    assign o_res.mean_second = r_o_mean[1];
    assign o_res.mean_third  = r_o_mean[2];
    assign o_res.group_end   = r_o_end;

    // The line RAM data must survive a stall of stage 1.
    a_rdata_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !adv) |=> $stable(rdata[0]) && $stable(rdata[3]))
        else $error("line RAM data changed under a stalled stage 1");

    // A burst never exceeds nine words.
    a_burst_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_v |-> r_e_n < 4'(MAX_RES))
        else $error("emitter exceeded nine results");

    // The input is held while a burst still has words to go.
    a_burst_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_v && !e_last) |-> !i_pix.ready)
        else $error("pixel accepted during a result burst");

    // Each accepted pixel advances the column or wraps it.
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !cfg_restart) |=> (r_col == $past(r_col) + CW'(1) || r_col == '0))
        else $error("column counter skipped");
endmodule

// ----- tb/tb_box_filter_5x5_rgb_edge_replicate.sv -----
// ----------------------------------------------------------------------------
// tb_box_filter_5x5_rgb_edge_replicate: self-checking bench of the mean filter
// Streams RGB frames of several sizes through the block, predicts every output
// word with its own line stores and 5x5 window, and compares them in order.
// ----------------------------------------------------------------------------
module tb_box_filter_5x5_rgb_edge_replicate
    import bfm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM   = 1024;
    localparam int SETTLE    = 20;
    localparam int HOLD_LEN  = 300;
    localparam int WDOG_MAX  = 5000;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        t_chan              first;
        t_chan              second;
        t_chan              third;
        logic               last;
    } t_out_pixel;

    typedef struct {
        t_chan first;
        t_chan second;
        t_chan third;
        bit    typed;
        t_chan mean_a;
        t_chan mean_b;
        t_chan mean_c;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    bfm_pix_if pix_ch ();
    bfm_res_if res_ch ();
    bfm_cfg_if cfg_ch ();

    box_filter_5x5_rgb_edge_replicate uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Shadow of the block: dimensions, line stores, window and position.
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [PIX_W-1:0] line_mem [4][MAX_DIM];
    logic [PIX_W-1:0] win [WINDOW][WINDOW];
    int               col_pos;
    int               row_pos;

    t_out_pixel       pending_means[$];
    int               mismatches;
    bit               calm;
    bit               hold_req;
    int               idle_cycles;
    t_stim_row        dir_tbl [25];

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int clamp_dim(logic [CFG_W-1:0] v);
        if (v < 5) return 5;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic t_chan window_mean(int sh);
        int sum;
        sum = 0;
        for (int i = 0; i < WINDOW; i++)
            for (int j = 0; j < WINDOW; j++)
                sum += (win[i][j] >> sh) & 8'hFF;
        return t_chan'((sum + ROUND) / 25);
    endfunction

    // Advance the shadow by one pixel and queue the words it should produce.
    function automatic void predict_means(logic [PIX_W-1:0] pix, bit typed,
                                          t_chan ea, t_chan eb, t_chan ec);
        int w, h, c, r, cx, cy, x0, x1, y0, y1, n;
        logic [PIX_W-1:0] col [WINDOW];
        t_out_pixel o;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        n = 0;
        for (int k = 0; k < 4; k++) col[k] = line_mem[(r + k) & 3][c];
        col[4] = pix;
        line_mem[r & 3][c] = pix;
        for (int k = 0; k < WINDOW; k++) begin
            for (int j = 0; j < WINDOW - 1; j++) win[k][j] = win[k][j+1];
            win[k][WINDOW-1] = col[k];
        end
        if (c >= 4 && r >= 4) begin
            cx = c - 2;
            cy = r - 2;
            x0 = (cx == 2) ? 0 : cx;
            x1 = (cx == w - 3) ? w - 1 : cx;
            y0 = (cy == 2) ? 0 : cy;
            y1 = (cy == h - 3) ? h - 1 : cy;
            o.first  = typed ? ea : window_mean(0);
            o.second = typed ? eb : window_mean(8);
            o.third  = typed ? ec : window_mean(16);
            // At most nine words per centre; the last one closes the group.
            for (int oy = y0; oy <= y1; oy++)
                for (int ox = x0; ox <= x1; ox++)
                    if (n < MAX_RES) begin
                        o.column = ox[COORD_W-1:0];
                        o.row    = oy[COORD_W-1:0];
                        o.last   = 1'b0;
                        pending_means.push_back(o);
                        n++;
                    end
            if (n > 0) pending_means[pending_means.size()-1].last = 1'b1;
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    // Offer one pixel until taken, then maybe leave a gap.
    task automatic send_pixel(t_chan a, t_chan b, t_chan c, bit typed,
                              t_chan ea, t_chan eb, t_chan ec);
        pix_ch.valid          <= 1'b1;
        pix_ch.channel_first  <= a;
        pix_ch.channel_second <= b;
        pix_ch.channel_third  <= c;
        do @(posedge i_clk); while (!pix_ch.ready);
        predict_means({c, b, a}, typed, ea, eb, ec);
        if (!calm && $urandom_range(0, 4) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    function automatic t_chan rand_chan();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return t_chan'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0, '0, '0, '0);
        pix_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Register writes happen only once the pipeline has emptied.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) width_reg = val;
        else height_reg = val;
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    // Result side: random stall bursts, one long hold-off on request.
    initial begin
        int  burst_left;
        int  hold_left;
        bit  stall_now;
        burst_left = 0;
        hold_left  = 0;
        stall_now  = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_LEN;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (calm) begin
                res_ch.ready <= 1'b1;
            end else begin
                if (burst_left == 0) begin
                    stall_now  = ($urandom_range(0, 2) == 0);
                    burst_left = stall_now ? $urandom_range(1, 18) : $urandom_range(1, 40);
                end
                burst_left--;
                res_ch.ready <= !stall_now;
            end
        end
    end

    // Compare each output word with the oldest prediction; watch for a hang.
    always @(posedge i_clk) begin
        t_out_pixel got, want;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((res_ch.valid && res_ch.ready) || (pix_ch.valid && pix_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("watchdog: no word moved for %0d cycles", WDOG_MAX);
                $display("tb_box_filter_5x5_rgb_edge_replicate: done, errors");
                $finish;
            end
            if (res_ch.valid && res_ch.ready) begin
                got = '{res_ch.out_column, res_ch.out_row, res_ch.mean_first,
                        res_ch.mean_second, res_ch.mean_third, res_ch.group_end};
                if (pending_means.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: col %0d row %0d", got.column, got.row);
                end else begin
                    want = pending_means.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected c%0d r%0d %0d/%0d/%0d e%0d,",
                                      " got c%0d r%0d %0d/%0d/%0d e%0d"},
                                     want.column, want.row, want.first, want.second,
                                     want.third, want.last, got.column, got.row,
                                     got.first, got.second, got.third, got.last);
                    end
                end
            end
        end
    end

    // Main sequence.
    initial begin
        pix_ch.valid          = 1'b0;
        pix_ch.channel_first  = '0;
        pix_ch.channel_second = '0;
        pix_ch.channel_third  = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_IMAGE_WIDTH;
        cfg_ch.data           = '0;
        i_rst_n               = 1'b0;
        calm                  = 1'b0;
        hold_req              = 1'b0;
        mismatches            = 0;
        width_reg             = WIDTH_RESET;
        height_reg            = HEIGHT_RESET;
        col_pos               = 0;
        row_pos               = 0;
        for (int i = 0; i < WINDOW; i++)
            for (int j = 0; j < WINDOW; j++) win[i][j] = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest frame of pixels FF/00/FF: the single centre covers the
        // whole frame, but only nine words come out, with means FF, 00 and FF.
        dir_tbl = '{default: '{8'hFF, 8'h00, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00}};
        dir_tbl[24].typed  = 1'b1;
        dir_tbl[24].mean_a = 8'hFF;
        dir_tbl[24].mean_b = 8'h00;
        dir_tbl[24].mean_c = 8'hFF;
        set_frame(11'd5, 11'd5);
        foreach (dir_tbl[i])
            send_pixel(dir_tbl[i].first, dir_tbl[i].second, dir_tbl[i].third,
                       dir_tbl[i].typed, dir_tbl[i].mean_a, dir_tbl[i].mean_b,
                       dir_tbl[i].mean_c);
        pix_ch.valid <= 1'b0;

        // Width below range saturates to five, tallest frame.
        set_frame(11'd0, 11'd1024);
        send_random(45);

        // Full frame plus a wrap into the next, with a long output hold-off
        // and a pause until everything has drained.
        set_frame(11'd8, 11'd6);
        hold_req = 1'b1;
        send_random(30);
        drain();
        send_random(38);

        // Widest frames, width beyond range and height below range: no centres.
        set_frame(11'd1024, 11'd0);
        send_random(8);
        set_frame(11'd2047, 11'd1024);
        send_random(8);

        // Final frame without idling on either side.
        set_frame(11'd9, 11'd8);
        calm = 1'b1;
        send_random(72);

        drain();
        if (mismatches == 0)
            $display("tb_box_filter_5x5_rgb_edge_replicate: done, clean");
        else
            $display("tb_box_filter_5x5_rgb_edge_replicate: done, errors");
        $finish;
    end

endmodule
